FILE: rtl/cda_pkg.sv
package cda_pkg;

   localparam int YEAR_BITS  = 14;
   localparam int COUNT_BITS = 20;

   localparam int MODE_W  = 3;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 20;
   localparam int DIFF_W  = 22;
   localparam int CMP_W   = 2;

   localparam int NUM_W   = 22;
   localparam int QUOT_W  = 8;
   localparam int RECIP_W = 16;
   localparam int PROD_W  = NUM_W + RECIP_W;

   localparam int YEAR_LIMIT = (((1 << YEAR_BITS) - 1) < 9999) ? ((1 << YEAR_BITS) - 1) : 9999;
   localparam int LAST_DAY   = 365 * YEAR_LIMIT + YEAR_LIMIT / 4 - YEAR_LIMIT / 100
                               + YEAR_LIMIT / 400 - 1;
   localparam logic [COUNT_W-1:0] COUNT_MASK = COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

   localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIFF    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COMPARE = 3'd4;

   localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd0;
   localparam logic [CMP_W-1:0] CMP_LATER   = 2'd1;
   localparam logic [CMP_W-1:0] CMP_EARLIER = 2'd2;

   localparam logic [NUM_W-1:0] DIV_CENTURY = 22'd100;
   localparam logic [NUM_W-1:0] DIV_400Y    = 22'd146097;
   localparam logic [NUM_W-1:0] DIV_100Y    = 22'd36524;
   localparam logic [NUM_W-1:0] DIV_4Y      = 22'd1461;
   localparam logic [NUM_W-1:0] DIV_1Y      = 22'd365;

   // Each reciprocal is the floor of 2**NUM_W over its divisor, so the quotient
   // estimate is never high and at most one low.
   localparam logic [RECIP_W-1:0] RCP_CENTURY = 16'd41943;
   localparam logic [RECIP_W-1:0] RCP_400Y    = 16'd28;
   localparam logic [RECIP_W-1:0] RCP_100Y    = 16'd114;
   localparam logic [RECIP_W-1:0] RCP_4Y      = 16'd2870;
   localparam logic [RECIP_W-1:0] RCP_1Y      = 16'd11491;

   typedef enum logic [2:0] {
      DIV_HELD_Y  = 3'd0,
      DIV_OTHER_Y = 3'd1,
      DIV_Q400    = 3'd2,
      DIV_Q100    = 3'd3,
      DIV_Q4      = 3'd4,
      DIV_Q1      = 3'd5
   } div_op_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [YEAR_W-1:0]  other_year;
      logic [MONTH_W-1:0] other_month;
      logic [DAY_W-1:0]   other_day;
      logic [COUNT_W-1:0] day_count;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  cur_year;
      logic [MONTH_W-1:0] cur_month;
      logic [DAY_W-1:0]   cur_day;
      logic [DIFF_W-1:0]  day_difference;
      logic [CMP_W-1:0]   compare_result;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      div_op_type div_op;
      logic       num_a;
      logic       num_b;
      logic       num_c;
      logic       num_other;
      logic       exec;
      logic       year;
      logic       walk;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic mode_other;
      logic need_conv;
      logic walk_done;
      logic out_free;
   } sts_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/cda_div.sv
module cda_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  cda_pkg::div_op_type        op,
   input  logic [cda_pkg::NUM_W-1:0]  dividend,
   output logic                       busy,
   output logic                       done,
   output logic [cda_pkg::QUOT_W-1:0] quot,
   output logic [cda_pkg::NUM_W-1:0]  rem
);
   import cda_pkg::*;

   logic [2:0]         stage_ff;
   logic               done_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   divisor_ff;
   logic [NUM_W-1:0]   qd_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [NUM_W-1:0]   rem_ff;
   logic [NUM_W-1:0]   divisor;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      case (op)
         DIV_HELD_Y, DIV_OTHER_Y: begin divisor = DIV_CENTURY; recip = RCP_CENTURY; end
         DIV_Q400:                begin divisor = DIV_400Y;    recip = RCP_400Y;    end
         DIV_Q100:                begin divisor = DIV_100Y;    recip = RCP_100Y;    end
         DIV_Q4:                  begin divisor = DIV_4Y;      recip = RCP_4Y;      end
         DIV_Q1:                  begin divisor = DIV_1Y;      recip = RCP_1Y;      end
         default:                 begin divisor = DIV_1Y;      recip = RCP_1Y;      end
      endcase
   end

   assign prod = PROD_W'(dividend) * PROD_W'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= {stage_ff[1:0], start};
         done_ff  <= stage_ff[2];
      end
   end

   // Estimate, back-multiply, subtract, then correct an estimate that is one low.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff     <= dividend;
         divisor_ff <= divisor;
         quot_ff    <= prod[NUM_W +: QUOT_W];
      end
      if (stage_ff[0]) begin
         qd_ff <= NUM_W'(quot_ff) * divisor_ff;
      end
      if (stage_ff[1]) begin
         rem_ff <= num_ff - qd_ff;
      end
      if (stage_ff[2] && (rem_ff >= divisor_ff)) begin
         quot_ff <= quot_ff + QUOT_W'(1);
         rem_ff  <= rem_ff - divisor_ff;
      end
   end

   assign busy = |stage_ff;
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/cda_dpath.sv
module cda_dpath (
   input  logic             clock,
   input  logic             reset,
   input  cda_pkg::req_type req_data,
   input  cda_pkg::cmd_type cmd,
   output cda_pkg::sts_type sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   req_type             item_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [YEAR_W-1:0]   held_year_ff;
   logic [MONTH_W-1:0]  held_month_ff;
   logic [DAY_W-1:0]    held_day_ff;
   div_op_type          div_op_ff;
   logic [QUOT_W-1:0]   yq_ff;
   logic                yrz_ff;
   logic [NUM_W-1:0]    acc_ff;
   logic [NUM_W-1:0]    cur_ff;
   logic [NUM_W-1:0]    oth_ff;
   logic                valid_ff;
   logic [NUM_W-1:0]    r_ff;
   logic [4:0]          q400_ff;
   logic [1:0]          q100_ff;
   logic [4:0]          q4_ff;
   logic [1:0]          q1_ff;
   logic                leapn_ff;
   logic [MONTH_W-1:0]  mo_ff;
   logic                err_ff;
   logic [DIFF_W-1:0]   diff_ff;
   logic [CMP_W-1:0]    cmp_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [NUM_W-1:0]    dividend;
   logic                div_busy;
   logic                div_done;
   logic [QUOT_W-1:0]   div_quot;
   logic [NUM_W-1:0]    div_rem;
   logic [NUM_W-1:0]    r_in;

   logic [YEAR_W-1:0]   w_year;
   logic [MONTH_W-1:0]  w_month;
   logic [DAY_W-1:0]    w_day;
   logic [YEAR_W-1:0]   w_p;
   logic [QUOT_W-1:0]   w_pq;
   logic                w_leap;
   logic                w_ok;
   logic [NUM_W-1:0]    w_small;

   logic                add_over;
   logic                sub_under;
   logic [NUM_W-1:0]    conv_n;
   logic [CMP_W-1:0]    cmp_in;
   logic                walk_more;
   logic [DAY_W-1:0]    walk_len;

   // The date being turned into a day number: held date or the word's date.
   assign w_year  = cmd.num_other ? item_ff.other_year  : held_year_ff;
   assign w_month = cmd.num_other ? item_ff.other_month : held_month_ff;
   assign w_day   = cmd.num_other ? item_ff.other_day   : held_day_ff;
   assign w_p     = w_year - YEAR_W'(1);
   assign w_pq    = yrz_ff ? yq_ff - QUOT_W'(1) : yq_ff;
   assign w_leap  = (w_year[1:0] == 2'b00) && (!yrz_ff || (yq_ff[1:0] == 2'b00));
   assign w_ok    = (w_year >= YEAR_W'(1)) && (w_year <= YEAR_W'(YEAR_LIMIT))
                    && (w_month inside {[4'd1:4'd12]}) && (w_day >= DAY_W'(1))
                    && (w_day <= month_days(w_month, w_leap));
   assign w_small = NUM_W'(days_before(w_month))
                    + ((w_leap && (w_month > 4'd2)) ? NUM_W'(1) : NUM_W'(0))
                    + NUM_W'(w_day) - NUM_W'(1);

   assign add_over  = NUM_W'(cnt_ff) > (NUM_W'(LAST_DAY) - cur_ff);
   assign sub_under = NUM_W'(cnt_ff) > cur_ff;
   assign conv_n    = (item_ff.mode == MODE_ADD) ? cur_ff + NUM_W'(cnt_ff)
                                                 : cur_ff - NUM_W'(cnt_ff);

   always_comb begin
      if (held_year_ff != item_ff.other_year) begin
         cmp_in = (held_year_ff > item_ff.other_year) ? CMP_LATER : CMP_EARLIER;
      end else if (held_month_ff != item_ff.other_month) begin
         cmp_in = (held_month_ff > item_ff.other_month) ? CMP_LATER : CMP_EARLIER;
      end else if (held_day_ff != item_ff.other_day) begin
         cmp_in = (held_day_ff > item_ff.other_day) ? CMP_LATER : CMP_EARLIER;
      end else begin
         cmp_in = CMP_EQUAL;
      end
   end

   // Remainder after a finished division, with the last-day-of-cycle clamp.
   always_comb begin
      case (div_op_ff)
         DIV_Q100: r_in = div_quot[2] ? div_rem + DIV_100Y : div_rem;
         DIV_Q1:   r_in = div_quot[2] ? div_rem + DIV_1Y : div_rem;
         default:  r_in = div_rem;
      endcase
   end

   always_comb begin
      case (cmd.div_op)
         DIV_HELD_Y:  dividend = NUM_W'(held_year_ff);
         DIV_OTHER_Y: dividend = NUM_W'(item_ff.other_year);
         DIV_Q400:    dividend = conv_n;
         default:     dividend = r_in;
      endcase
   end

   cda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .op       (cmd.div_op),
      .dividend (dividend),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign walk_len  = month_days(mo_ff, leapn_ff);
   assign walk_more = (mo_ff < 4'd12) && (r_ff >= NUM_W'(walk_len));

   always_ff @(posedge clock) begin
      if (reset) begin
         held_year_ff  <= YEAR_W'(1);
         held_month_ff <= MONTH_W'(1);
         held_day_ff   <= DAY_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.exec && (item_ff.mode == MODE_LOAD) && valid_ff) begin
            held_year_ff  <= item_ff.other_year;
            held_month_ff <= item_ff.other_month;
            held_day_ff   <= item_ff.other_day;
         end else if (cmd.year) begin
            held_year_ff <= YEAR_W'(q400_ff) * YEAR_W'(400) + YEAR_W'(q100_ff) * YEAR_W'(100)
                            + YEAR_W'(q4_ff) * YEAR_W'(4) + YEAR_W'(q1_ff) + YEAR_W'(1);
         end else if (cmd.walk && !walk_more) begin
            held_month_ff <= mo_ff;
            held_day_ff   <= DAY_W'(r_ff) + DAY_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         cnt_ff  <= req_data.day_count & COUNT_MASK;
         err_ff  <= 1'b0;
         diff_ff <= '0;
         cmp_ff  <= CMP_EQUAL;
      end
      if (cmd.div_start) begin
         div_op_ff <= cmd.div_op;
      end
      if (div_done) begin
         case (div_op_ff)
            DIV_HELD_Y, DIV_OTHER_Y: begin
               yq_ff  <= div_quot;
               yrz_ff <= (div_rem == '0);
            end
            DIV_Q400: begin
               q400_ff <= div_quot[4:0];
               r_ff    <= r_in;
            end
            DIV_Q100: begin
               q100_ff <= div_quot[2] ? 2'd3 : div_quot[1:0];
               r_ff    <= r_in;
            end
            DIV_Q4: begin
               q4_ff <= div_quot[4:0];
               r_ff  <= r_in;
            end
            DIV_Q1: begin
               q1_ff <= div_quot[2] ? 2'd3 : div_quot[1:0];
               r_ff  <= r_in;
            end
            default: begin
               r_ff <= r_in;
            end
         endcase
      end else if (cmd.walk && walk_more) begin
         r_ff  <= r_ff - NUM_W'(walk_len);
         mo_ff <= mo_ff + MONTH_W'(1);
      end
      if (cmd.year) begin
         leapn_ff <= (q1_ff == 2'd3) && ((q4_ff != 5'd24) || (q100_ff == 2'd3));
         mo_ff    <= MONTH_W'(1);
      end
      if (cmd.num_a) begin
         acc_ff <= NUM_W'(w_p) * NUM_W'(365);
         if (cmd.num_other) begin
            valid_ff <= w_ok;
         end
      end
      if (cmd.num_b) begin
         acc_ff <= acc_ff + NUM_W'(w_p >> 2) + NUM_W'(w_pq >> 2) - NUM_W'(w_pq);
      end
      if (cmd.num_c) begin
         if (cmd.num_other) begin
            oth_ff <= acc_ff + w_small;
         end else begin
            cur_ff <= acc_ff + w_small;
         end
      end
      if (cmd.exec) begin
         case (item_ff.mode)
            MODE_LOAD:    err_ff <= !valid_ff;
            MODE_ADD:     err_ff <= add_over;
            MODE_SUB:     err_ff <= sub_under;
            MODE_DIFF: begin
               err_ff <= !valid_ff;
               if (valid_ff) begin
                  diff_ff <= (cur_ff >= oth_ff) ? cur_ff - oth_ff : oth_ff - cur_ff;
               end
            end
            MODE_COMPARE: begin
               err_ff <= !valid_ff;
               cmp_ff <= cmp_in;
            end
            default:      err_ff <= 1'b0;
         endcase
      end
      if (cmd.out_load) begin
         rsp_data_ff.cur_year       <= held_year_ff;
         rsp_data_ff.cur_month      <= held_month_ff;
         rsp_data_ff.cur_day        <= held_day_ff;
         rsp_data_ff.day_difference <= diff_ff;
         rsp_data_ff.compare_result <= cmp_ff;
         rsp_data_ff.range_error    <= err_ff;
      end
   end

   assign sts.div_busy   = div_busy;
   assign sts.div_done   = div_done;
   assign sts.mode_other = item_ff.mode inside {MODE_LOAD, MODE_DIFF, MODE_COMPARE};
   assign sts.need_conv  = ((item_ff.mode == MODE_ADD) && !add_over)
                           || ((item_ff.mode == MODE_SUB) && !sub_under);
   assign sts.walk_done  = !walk_more;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/cda_ctrl.sv
module cda_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cda_pkg::sts_type sts,
   output cda_pkg::cmd_type cmd
);
   import cda_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_HDIV = 14'b00000000000010,
      ST_HNA  = 14'b00000000000100,
      ST_HNB  = 14'b00000000001000,
      ST_HNC  = 14'b00000000010000,
      ST_ODIV = 14'b00000000100000,
      ST_ONA  = 14'b00000001000000,
      ST_ONB  = 14'b00000010000000,
      ST_ONC  = 14'b00000100000000,
      ST_EXEC = 14'b00001000000000,
      ST_YDIV = 14'b00010000000000,
      ST_YEAR = 14'b00100000000000,
      ST_WALK = 14'b01000000000000,
      ST_DONE = 14'b10000000000000
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [1:0] ydiv_ff;
   logic [1:0] ydiv_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ydiv_in  = ydiv_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_HELD_Y;
               state_in      = ST_HDIV;
            end
         end
         ST_HDIV: begin
            if (sts.div_done) begin
               state_in = ST_HNA;
            end
         end
         ST_HNA: begin
            cmd.num_a = 1'b1;
            state_in  = ST_HNB;
         end
         ST_HNB: begin
            cmd.num_b = 1'b1;
            state_in  = ST_HNC;
         end
         ST_HNC: begin
            cmd.num_c = 1'b1;
            if (sts.mode_other) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OTHER_Y;
               state_in      = ST_ODIV;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_ODIV: begin
            if (sts.div_done) begin
               state_in = ST_ONA;
            end
         end
         ST_ONA: begin
            cmd.num_a     = 1'b1;
            cmd.num_other = 1'b1;
            state_in      = ST_ONB;
         end
         ST_ONB: begin
            cmd.num_b     = 1'b1;
            cmd.num_other = 1'b1;
            state_in      = ST_ONC;
         end
         ST_ONC: begin
            cmd.num_c     = 1'b1;
            cmd.num_other = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_conv) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_Q400;
               ydiv_in       = 2'd0;
               state_in      = ST_YDIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_YDIV: begin
            if (sts.div_done) begin
               case (ydiv_ff)
                  2'd0: begin
                     cmd.div_start = 1'b1;
                     cmd.div_op    = DIV_Q100;
                     ydiv_in       = 2'd1;
                  end
                  2'd1: begin
                     cmd.div_start = 1'b1;
                     cmd.div_op    = DIV_Q4;
                     ydiv_in       = 2'd2;
                  end
                  2'd2: begin
                     cmd.div_start = 1'b1;
                     cmd.div_op    = DIV_Q1;
                     ydiv_in       = 2'd3;
                  end
                  default: begin
                     state_in = ST_YEAR;
                  end
               endcase
            end
         end
         ST_YEAR: begin
            cmd.year = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ydiv_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         ydiv_ff  <= ydiv_in;
      end
   end

endmodule

FILE: rtl/calendar_date_arithmetic_top.sv
// Channel  Dir  Handshake             Word
// req      in   req_valid/req_ready   cda_pkg::req_type
// rsp      out  rsp_valid/rsp_ready   cda_pkg::rsp_type
//
// A load, difference or compare converts the held date and the word's date; a refused add
// or subtract or an unused mode converts only the held date; an accepted add or subtract
// then runs four divisions, builds the year and walks the months. One divider is shared.
// Reset is synchronous and sets the held date to year 1, January 1.
// A new word is taken only when idle, in the cycle after the last result is loaded; that
// result waits in the output register, and the next result waits for it to drain.
module calendar_date_arithmetic_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cda_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result not presented after load");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_month >= 4'd1) && (rsp_data.cur_month <= 4'd12)
                    && (rsp_data.cur_day >= 5'd1))
      else $error("result date out of range");

   a_err_no_diff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_error) |-> (rsp_data.day_difference == '0))
      else $error("difference reported with range error");

endmodule

FILE: dv/date_check_pkg.sv
`timescale 1ns / 100ps

package date_check_pkg;

   import cda_pkg::*;

   class date_tracker;

      logic [YEAR_W-1:0]  held_year;
      logic [MONTH_W-1:0] held_month;
      logic [DAY_W-1:0]   held_day;
      rsp_type            awaited_results[$];
      int unsigned        error_count;

      function new();
         held_year   = YEAR_W'(1);
         held_month  = MONTH_W'(1);
         held_day    = DAY_W'(1);
         error_count = 0;
      endfunction

      static function bit leap_year(int unsigned y);
         return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
      endfunction

      static function int unsigned month_length(int unsigned y, int unsigned m);
         int unsigned lengths[13];
         lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         if (m < 1 || m > 12) begin
            return 0;
         end
         return lengths[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
      endfunction

      static function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
         if (y < 1 || y > YEAR_LIMIT || m < 1 || m > 12) begin
            return 1'b0;
         end
         return d >= 1 && d <= month_length(y, m);
      endfunction

      static function int unsigned to_day_index(int unsigned y, int unsigned m,
                                                int unsigned d);
         int unsigned p;
         int unsigned n;
         p = y - 1;
         n = 365 * p + p / 4 - p / 100 + p / 400;
         for (int unsigned k = 1; k < m && k <= 12; k++) begin
            n += month_length(y, k);
         end
         return n + d - 1;
      endfunction

      static function void from_day_index(input int unsigned n, output int unsigned y,
                                          output int unsigned m, output int unsigned d);
         int unsigned q400, q100, q4, q1, r, mo;
         q400 = n / 146097;
         r    = n % 146097;
         q100 = r / 36524;
         if (q100 > 3) begin
            q100 = 3;
         end
         r  -= q100 * 36524;
         q4  = r / 1461;
         r   = r % 1461;
         q1  = r / 365;
         if (q1 > 3) begin
            q1 = 3;
         end
         r -= q1 * 365;
         y  = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
         mo = 1;
         while (mo < 12 && r >= month_length(y, mo)) begin
            r -= month_length(y, mo);
            mo++;
         end
         m = mo;
         d = r + 1;
      endfunction

      function rsp_type next_date_result(req_type w);
         rsp_type     res;
         int unsigned oy, om, od, cnt, cur, last, other, ny, nm, nd;
         bit          ok;
         oy  = w.other_year;
         om  = w.other_month;
         od  = w.other_day;
         cnt = w.day_count & COUNT_MASK;
         ok  = date_ok(oy, om, od);
         cur = to_day_index(held_year, held_month, held_day);
         res = '0;
         case (w.mode)
            MODE_LOAD: begin
               if (ok) begin
                  held_year  = YEAR_W'(oy);
                  held_month = MONTH_W'(om);
                  held_day   = DAY_W'(od);
               end else begin
                  res.range_error = 1'b1;
               end
            end
            MODE_ADD: begin
               last = to_day_index(YEAR_LIMIT, 12, 31);
               if (cnt > last - cur) begin
                  res.range_error = 1'b1;
               end else begin
                  from_day_index(cur + cnt, ny, nm, nd);
                  held_year  = YEAR_W'(ny);
                  held_month = MONTH_W'(nm);
                  held_day   = DAY_W'(nd);
               end
            end
            MODE_SUB: begin
               if (cnt > cur) begin
                  res.range_error = 1'b1;
               end else begin
                  from_day_index(cur - cnt, ny, nm, nd);
                  held_year  = YEAR_W'(ny);
                  held_month = MONTH_W'(nm);
                  held_day   = DAY_W'(nd);
               end
            end
            MODE_DIFF: begin
               if (ok) begin
                  other = to_day_index(oy, om, od);
                  res.day_difference = DIFF_W'(cur >= other ? cur - other : other - cur);
               end else begin
                  res.range_error = 1'b1;
               end
            end
            MODE_COMPARE: begin
               if (held_year != oy) begin
                  res.compare_result = (held_year > oy) ? CMP_LATER : CMP_EARLIER;
               end else if (held_month != om) begin
                  res.compare_result = (held_month > om) ? CMP_LATER : CMP_EARLIER;
               end else if (held_day != od) begin
                  res.compare_result = (held_day > od) ? CMP_LATER : CMP_EARLIER;
               end
               res.range_error = !ok;
            end
            default: begin
            end
         endcase
         res.cur_year  = held_year;
         res.cur_month = held_month;
         res.cur_day   = held_day;
         return res;
      endfunction

      function void note_request(req_type w);
         awaited_results.push_back(next_date_result(w));
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         error_count++;
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report($sformatf("%s is %0d, expected %0d", name, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            report("result word arrived with nothing outstanding");
            return;
         end
         want = awaited_results.pop_front();
         check_field("cur_year", got.cur_year, want.cur_year);
         check_field("cur_month", got.cur_month, want.cur_month);
         check_field("cur_day", got.cur_day, want.cur_day);
         check_field("day_difference", got.day_difference, want.day_difference);
         check_field("compare_result", got.compare_result, want.compare_result);
         check_field("range_error", got.range_error, want.range_error);
      endtask

   endclass

endpackage

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   import cda_pkg::*;
   import date_check_pkg::*;

   localparam int RANDOM_WORDS    = 1100;
   localparam int QUIET_TAIL      = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_AT         = 300;
   localparam int DRAIN_AT        = 600;
   localparam int SETTLE_CYCLES   = 200;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   date_tracker tracker = new();
   bit          bursts_on = 1'b0;
   int          hold_cycles = 0;
   int          stall_left = 0;
   int unsigned last_year = 1;
   int unsigned last_month = 1;
   int unsigned last_day = 1;

   calendar_date_arithmetic_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_data);
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_word(logic [MODE_W-1:0] mode, int unsigned y,
                                         int unsigned m, int unsigned d,
                                         int unsigned cnt);
      req_type w;
      w.mode        = mode;
      w.other_year  = YEAR_W'(y);
      w.other_month = MONTH_W'(m);
      w.other_day   = DAY_W'(d);
      w.day_count   = COUNT_W'(cnt);
      return w;
   endfunction

   task automatic random_valid_date(output int unsigned y, output int unsigned m,
                                    output int unsigned d);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         y = $urandom_range(1, YEAR_LIMIT);
      end else if (pick < 75) begin
         y = $urandom_range(1, 4);
      end else if (pick < 90) begin
         y = $urandom_range(YEAR_LIMIT - 3, YEAR_LIMIT);
      end else begin
         y = $urandom_range(1895, 2105);
      end
      m = $urandom_range(1, 12);
      d = $urandom_range(1, date_tracker::month_length(y, m));
   endtask

   task automatic random_word(output req_type w);
      int unsigned pick, y, m, d, cnt;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w.mode        = MODE_W'($urandom);
         w.other_year  = YEAR_W'($urandom);
         w.other_month = MONTH_W'($urandom);
         w.other_day   = DAY_W'($urandom);
         w.day_count   = COUNT_W'($urandom);
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         mode = MODE_LOAD;
      end else if (pick < 45) begin
         mode = MODE_ADD;
      end else if (pick < 70) begin
         mode = MODE_SUB;
      end else if (pick < 85) begin
         mode = MODE_DIFF;
      end else begin
         mode = MODE_COMPARE;
      end
      random_valid_date(y, m, d);
      if ((mode == MODE_DIFF || mode == MODE_COMPARE) && $urandom_range(0, 2) == 0) begin
         y = last_year;
         m = last_month;
         d = last_day;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         d = $urandom_range(1, 31);
      end else if (pick < 8) begin
         m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         cnt = $urandom_range(0, 400);
      end else if (pick < 80) begin
         cnt = $urandom_range(0, 40000);
      end else begin
         cnt = $urandom;
      end
      if (mode == MODE_LOAD) begin
         last_year  = y;
         last_month = m;
         last_day   = d;
      end
      w = make_word(mode, y, m, d, cnt);
   endtask

   task automatic send_word(req_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (tracker.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      req_type w;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(make_word(MODE_LOAD, YEAR_LIMIT, 12, 31, 0));
      send_word(make_word(MODE_ADD, 0, 0, 0, 1));
      send_word(make_word(MODE_ADD, 0, 0, 0, 0));
      send_word(make_word(MODE_COMPARE, YEAR_LIMIT, 12, 31, 0));
      send_word(make_word(MODE_LOAD, 1, 1, 1, 0));
      send_word(make_word(MODE_SUB, 0, 0, 0, 1));
      send_word(make_word(MODE_SUB, 0, 0, 0, 0));
      send_word(make_word(MODE_ADD, 0, 0, 0, COUNT_MASK));
      send_word(make_word(MODE_SUB, 0, 0, 0, COUNT_MASK));
      send_word(make_word(MODE_LOAD, 2000, 2, 29, 0));
      send_word(make_word(MODE_LOAD, 1900, 2, 29, 0));
      send_word(make_word(MODE_LOAD, 0, 1, 1, 0));
      send_word(make_word(MODE_LOAD, 16383, 15, 31, COUNT_MASK));
      send_word(make_word(MODE_LOAD, 2001, 13, 1, 0));
      send_word(make_word(MODE_LOAD, 2001, 4, 31, 0));
      send_word(make_word(MODE_LOAD, 2001, 1, 0, 0));
      send_word(make_word(MODE_DIFF, 1, 1, 1, 0));
      send_word(make_word(MODE_DIFF, 2001, 2, 29, 0));
      send_word(make_word(MODE_COMPARE, 1999, 12, 31, 0));
      send_word(make_word(MODE_COMPARE, 2000, 3, 1, 0));
      send_word(make_word(MODE_COMPARE, 2000, 2, 30, 0));
      send_word(make_word(MODE_SUB, 0, 0, 0, 365));
      send_word(make_word(MODE_SPARE_A, 0, 0, 0, COUNT_MASK));
      send_word(make_word(MODE_SPARE_B, 16383, 15, 31, 0));
      send_word(make_word(MODE_SPARE_C, 1, 1, 1, 1));

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         bursts_on = (i < RANDOM_WORDS - QUIET_TAIL) && ((i / 100) % 4 != 3);
         if (i == HOLD_AT) begin
            hold_cycles = HOLD_OFF_CYCLES;
         end
         if (i == DRAIN_AT) begin
            idle_sender(1);
            wait_drained();
         end
         if (bursts_on && $urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 9));
         end
         random_word(w);
         send_word(w);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.outstanding() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/cda_pkg.sv
rtl/cda_div.sv
rtl/cda_dpath.sv
rtl/cda_ctrl.sv
rtl/calendar_date_arithmetic_top.sv
dv/date_check_pkg.sv
dv/testbench.sv
